>>> rtl/cpclip_pkg.sv
// ----------------------------------------------------------------------------
// cpclip_pkg
// Shared types and constants of the convex polygon segment clip test.
// ----------------------------------------------------------------------------
package cpclip_pkg;

  localparam int FIELD_W     = 16;
  localparam int IDX_W       = 4;
  localparam int CNT_FIELD_W = 5;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 8;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;
  localparam int MIN_VERTICES = 3;

  localparam logic OPC_VERTEX  = 1'b0;
  localparam logic OPC_SEGMENT = 1'b1;

  // Register index as decoded from the word address bit of paddr.
  localparam logic REG_VERTEX_COUNT = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_V0,
    ST_RD,
    ST_NRM,
    ST_PN_A,
    ST_PN_B,
    ST_QN_A,
    ST_QN_B,
    ST_EVAL,
    ST_CM_0,
    ST_CM_1,
    ST_CM_2,
    ST_CM_3,
    ST_TEST,
    ST_DONE
  } ctl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_V0,
    OP_NRM,
    OP_PN_A,
    OP_PN_B,
    OP_QN_A,
    OP_QN_B,
    OP_EVAL,
    OP_CM_0,
    OP_CM_1,
    OP_CM_2,
    OP_CM_3,
    OP_UPD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   pass;
    logic   last;
    logic   wr_vtx;
    logic   load_seg;
  } ctl_cmd_t;

  typedef struct packed {
    logic pn_zero;
    logic qn_neg;
    logic hit;
  } dp_stat_t;

endpackage

>>> rtl/cpclip_dp.sv
// ----------------------------------------------------------------------------
// cpclip_dp
// Datapath: vertex memory, edge normals, one shared multiply-accumulate unit
// and the entry and exit fractions of the edge test.
// ----------------------------------------------------------------------------
module cpclip_dp #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 16,
  localparam int AW = $clog2(MAX_VERTICES)
) (
  input  logic                                   clk,
  input  cpclip_pkg::ctl_cmd_t                   cmd,
  input  logic [AW-1:0]                          rd_addr,
  input  logic [cpclip_pkg::IDX_W-1:0]           in_vertex_index,
  input  logic signed [cpclip_pkg::FIELD_W-1:0]  in_start_x,
  input  logic signed [cpclip_pkg::FIELD_W-1:0]  in_start_y,
  input  logic signed [cpclip_pkg::FIELD_W-1:0]  in_end_x,
  input  logic signed [cpclip_pkg::FIELD_W-1:0]  in_end_y,
  output cpclip_pkg::dp_stat_t                   stat
);
  import cpclip_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int DW = C + 1;
  localparam int M  = 2 * C + 3;
  localparam int D  = C + 2;
  localparam int DB = D + 1;
  localparam int AC = 2 * M;
  localparam int PW = M + DB;
  localparam int MOD_STEPS = (2 ** IDX_W) / MAX_VERTICES;

  function automatic logic signed [C-1:0] to_coord(input logic [FIELD_W-1:0] f);
    logic signed [39:0] w;
    w = 40'(signed'(f));
    return w[C-1:0];
  endfunction

  logic signed [C-1:0]  vx_mem_r [MAX_VERTICES];
  logic signed [C-1:0]  vy_mem_r [MAX_VERTICES];
  logic signed [C-1:0]  rd_x_r, rd_y_r;
  logic [IDX_W:0]       idx_mod;
  logic [AW-1:0]        wr_addr;

  logic signed [C-1:0]  seg_sx, seg_sy, seg_ex, seg_ey;
  logic signed [C-1:0]  sx_r, sy_r, v0x_r, v0y_r, px_r, py_r, jx, jy;
  logic signed [DW-1:0] dx_r, dy_r, nx_r, ny_r, wx_r, wy_r;
  logic signed [AC-1:0] acc_r, acc_nxt, term, term_sh;
  logic signed [M-1:0]  pn_r, qn, rn_r, rd_r;
  logic signed [M-1:0]  en_n_r, en_d_r, ex_n_r, ex_d_r, bn, bd;
  logic                 pn_neg_r, use_en;
  logic signed [M-1:0]  mul_a;
  logic signed [DB-1:0] mul_b, bd_lo, bd_hi, rd_lo, rd_hi;
  logic signed [PW-1:0] prod;
  logic                 acc_clr, acc_en, acc_sub, acc_hi;

  assign seg_sx = to_coord(in_start_x);
  assign seg_sy = to_coord(in_start_y);
  assign seg_ex = to_coord(in_end_x);
  assign seg_ey = to_coord(in_end_y);

  always_comb begin
    idx_mod = {1'b0, in_vertex_index};
    for (int i = 0; i < MOD_STEPS; i++) begin
      if (int'(idx_mod) >= MAX_VERTICES) begin
        idx_mod = idx_mod - (IDX_W + 1)'(MAX_VERTICES);
      end
    end
  end

  assign wr_addr = AW'(idx_mod);

  always_ff @(posedge clk) begin
    if (cmd.wr_vtx) begin
      vx_mem_r[wr_addr] <= seg_sx;
      vy_mem_r[wr_addr] <= seg_sy;
    end
    rd_x_r <= vx_mem_r[rd_addr];
    rd_y_r <= vy_mem_r[rd_addr];
  end

  // The closing edge of the polygon ends at vertex 0.
  assign jx = cmd.last ? v0x_r : rd_x_r;
  assign jy = cmd.last ? v0y_r : rd_y_r;

  assign use_en = cmd.pass ^ pn_neg_r;
  assign bn     = use_en ? en_n_r : ex_n_r;
  assign bd     = use_en ? en_d_r : ex_d_r;
  assign bd_lo  = {1'b0, bd[D-1:0]};
  assign bd_hi  = DB'(signed'(bd[M-1:D]));
  assign rd_lo  = {1'b0, rd_r[D-1:0]};
  assign rd_hi  = DB'(signed'(rd_r[M-1:D]));
  assign qn     = acc_r[M-1:0];

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    acc_clr = 1'b0;
    acc_en  = 1'b0;
    acc_sub = 1'b0;
    acc_hi  = 1'b0;
    unique case (cmd.op)
      OP_PN_A: begin
        mul_a = M'(dx_r); mul_b = DB'(nx_r); acc_clr = 1'b1; acc_en = 1'b1;
      end
      OP_PN_B: begin
        mul_a = M'(dy_r); mul_b = DB'(ny_r); acc_en = 1'b1;
      end
      OP_QN_A: begin
        mul_a = M'(wx_r); mul_b = DB'(nx_r); acc_clr = 1'b1; acc_en = 1'b1;
      end
      OP_QN_B: begin
        mul_a = M'(wy_r); mul_b = DB'(ny_r); acc_en = 1'b1;
      end
      OP_CM_0: begin
        mul_a = rn_r; mul_b = bd_lo; acc_clr = 1'b1; acc_en = 1'b1;
      end
      OP_CM_1: begin
        mul_a = rn_r; mul_b = bd_hi; acc_hi = 1'b1; acc_en = 1'b1;
      end
      OP_CM_2: begin
        mul_a = bn; mul_b = rd_lo; acc_sub = 1'b1; acc_en = 1'b1;
      end
      OP_CM_3: begin
        mul_a = bn; mul_b = rd_hi; acc_sub = 1'b1; acc_hi = 1'b1; acc_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign term    = AC'(prod);
  assign term_sh = acc_hi ? (term <<< D) : term;
  assign acc_nxt = (acc_clr ? AC'(0) : acc_r) + (acc_sub ? -term_sh : term_sh);

  always_ff @(posedge clk) begin
    if (acc_en) begin
      acc_r <= acc_nxt;
    end
    if (cmd.load_seg) begin
      sx_r   <= seg_sx;
      sy_r   <= seg_sy;
      dx_r   <= DW'(seg_ex) - DW'(seg_sx);
      dy_r   <= DW'(seg_ey) - DW'(seg_sy);
      en_n_r <= '0;
      en_d_r <= M'(1);
      ex_n_r <= M'(1);
      ex_d_r <= M'(1);
    end
    unique case (cmd.op)
      OP_V0: begin
        v0x_r <= rd_x_r;
        v0y_r <= rd_y_r;
        px_r  <= rd_x_r;
        py_r  <= rd_y_r;
      end
      OP_NRM: begin
        nx_r <= DW'(py_r) - DW'(jy);
        ny_r <= DW'(jx) - DW'(px_r);
        wx_r <= DW'(sx_r) - DW'(px_r);
        wy_r <= DW'(sy_r) - DW'(py_r);
        px_r <= jx;
        py_r <= jy;
      end
      OP_QN_A: begin
        pn_r <= acc_r[M-1:0];
      end
      OP_EVAL: begin
        rn_r     <= pn_r[M-1] ? qn : -qn;
        rd_r     <= pn_r[M-1] ? -pn_r : pn_r;
        pn_neg_r <= pn_r[M-1];
      end
      OP_UPD: begin
        if (use_en) begin
          en_n_r <= rn_r;
          en_d_r <= rd_r;
        end else begin
          ex_n_r <= rn_r;
          ex_d_r <= rd_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.pn_zero = (pn_r == '0);
  assign stat.qn_neg  = acc_r[AC-1];
  assign stat.hit     = pn_neg_r ? acc_r[AC-1] : (!acc_r[AC-1] && (acc_r != '0));

endmodule

>>> rtl/cpclip_ctrl.sv
// ----------------------------------------------------------------------------
// cpclip_ctrl
// Controller: sequences vertex writes, the per-edge test steps of a segment
// and the output register.
// ----------------------------------------------------------------------------
module cpclip_ctrl #(
  parameter int MAX_VERTICES = 16,
  localparam int AW    = $clog2(MAX_VERTICES),
  localparam int CNT_W = $clog2(MAX_VERTICES + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_opcode,
  output logic                 in_ready,
  output logic                 out_valid,
  output logic                 out_visible,
  input  logic                 out_ready,
  input  logic [CNT_W-1:0]     vertex_count,
  input  cpclip_pkg::dp_stat_t stat,
  output cpclip_pkg::ctl_cmd_t cmd,
  output logic [AW-1:0]        rd_addr
);
  import cpclip_pkg::*;

  ctl_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] k_r, k_nxt, kp1;
  logic             pass_r, pass_nxt;
  logic             rej_r, rej_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_visible_r, out_visible_nxt;
  logic             last, out_free;

  assign kp1      = k_r + CNT_W'(1);
  assign last     = (k_r == vertex_count - CNT_W'(1));
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt       = state_r;
    k_nxt           = k_r;
    pass_nxt        = pass_r;
    rej_nxt         = rej_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_visible_nxt = out_visible_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_opcode == OPC_SEGMENT)) begin
          state_nxt = ST_V0;
          k_nxt     = '0;
          pass_nxt  = 1'b0;
          rej_nxt   = 1'b0;
        end
      end
      ST_V0:   state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_NRM;
      ST_NRM:  state_nxt = ST_PN_A;
      ST_PN_A: state_nxt = ST_PN_B;
      ST_PN_B: state_nxt = ST_QN_A;
      ST_QN_A: state_nxt = ST_QN_B;
      ST_QN_B: state_nxt = ST_EVAL;
      ST_EVAL: begin
        pass_nxt = 1'b0;
        if (!stat.pn_zero) begin
          state_nxt = ST_CM_0;
        end else if (stat.qn_neg) begin
          rej_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else if (last) begin
          state_nxt = ST_DONE;
        end else begin
          k_nxt     = kp1;
          state_nxt = ST_RD;
        end
      end
      ST_CM_0: state_nxt = ST_CM_1;
      ST_CM_1: state_nxt = ST_CM_2;
      ST_CM_2: state_nxt = ST_CM_3;
      ST_CM_3: state_nxt = ST_TEST;
      ST_TEST: begin
        if (!pass_r) begin
          if (stat.hit) begin
            rej_nxt   = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            pass_nxt  = 1'b1;
            state_nxt = ST_CM_0;
          end
        end else if (last) begin
          state_nxt = ST_DONE;
        end else begin
          k_nxt     = kp1;
          state_nxt = ST_RD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_visible_nxt = !rej_r;
          state_nxt       = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    cmd.op       = OP_NONE;
    cmd.pass     = pass_r;
    cmd.last     = last;
    cmd.wr_vtx   = 1'b0;
    cmd.load_seg = 1'b0;
    in_ready     = 1'b0;
    rd_addr      = kp1[AW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        rd_addr      = '0;
        cmd.wr_vtx   = in_valid && (in_opcode == OPC_VERTEX);
        cmd.load_seg = in_valid && (in_opcode == OPC_SEGMENT);
      end
      ST_V0:   cmd.op = OP_V0;
      ST_NRM:  cmd.op = OP_NRM;
      ST_PN_A: cmd.op = OP_PN_A;
      ST_PN_B: cmd.op = OP_PN_B;
      ST_QN_A: cmd.op = OP_QN_A;
      ST_QN_B: cmd.op = OP_QN_B;
      ST_EVAL: cmd.op = OP_EVAL;
      ST_CM_0: cmd.op = OP_CM_0;
      ST_CM_1: cmd.op = OP_CM_1;
      ST_CM_2: cmd.op = OP_CM_2;
      ST_CM_3: cmd.op = OP_CM_3;
      ST_TEST: begin
        if (pass_r && stat.hit) begin
          cmd.op = OP_UPD;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      pass_r      <= 1'b0;
      rej_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      pass_r      <= pass_nxt;
      rej_r       <= rej_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_visible_r <= out_visible_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;

endmodule

>>> rtl/convex_polygon_segment_clip_test_top.sv
// ----------------------------------------------------------------------------
// convex_polygon_segment_clip_test_top
// Cyrus-Beck visibility test of a segment against a convex polygon.
//
//   Channel | Direction | Contents
//   in_*    | slave     | tuser: opcode; tdata: vertex_index, start_x, start_y,
//           |           |        end_x, end_y
//   out_*   | master    | tdata: visible
//   cfg_*   | APB       | register 0 at byte address 0: vertex_count
//
// A vertex write gives no item. A segment is tested edge by edge on the shared
// multiply-accumulate unit; an edge parallel to it skips the fraction steps.
// out_tvalid rises when the test of the segment ends, unless an earlier result
// still waits on out_tready.
// Reset is synchronous; the vertex memory is not cleared.
// The output register lets in_tready rise while a result waits on out_tready.
// ----------------------------------------------------------------------------
module convex_polygon_segment_clip_test_top #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [3:0] vertex_index, [19:4] start_x, [35:20] start_y, [51:36] end_x,
  // [67:52] end_y, [71:68] zero
  input  logic [cpclip_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] opcode
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [0] visible, [7:1] zero
  output logic [cpclip_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [cpclip_pkg::APB_AW-1:0]         cfg_paddr,
  input  logic [cpclip_pkg::APB_DW-1:0]         cfg_pwdata,
  output logic [cpclip_pkg::APB_DW-1:0]         cfg_prdata,
  output logic                                  cfg_pready
);
  import cpclip_pkg::*;

  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  logic [CNT_W-1:0]       vertex_count_r, vertex_count_nxt;
  logic [CNT_FIELD_W-1:0] cnt_field;
  logic                   cfg_wr;
  logic                   out_visible;
  ctl_cmd_t               cmd;
  dp_stat_t               stat;
  logic [AW-1:0]          rd_addr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_VERTEX_COUNT);
  assign cnt_field  = cfg_pwdata[CNT_FIELD_W-1:0];

  always_comb begin
    vertex_count_nxt = vertex_count_r;
    if (cfg_wr) begin
      priority if (int'(cnt_field) < MIN_VERTICES) begin
        vertex_count_nxt = CNT_W'(MIN_VERTICES);
      end else if (int'(cnt_field) > MAX_VERTICES) begin
        vertex_count_nxt = CNT_W'(MAX_VERTICES);
      end else begin
        vertex_count_nxt = CNT_W'(cnt_field);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= CNT_W'(MIN_VERTICES);
    end else begin
      vertex_count_r <= vertex_count_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_VERTEX_COUNT) ? APB_DW'(vertex_count_r) : '0;

  cpclip_ctrl #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_opcode   (in_tuser),
    .in_ready    (in_tready),
    .out_valid   (out_tvalid),
    .out_visible (out_visible),
    .out_ready   (out_tready),
    .vertex_count(vertex_count_r),
    .stat        (stat),
    .cmd         (cmd),
    .rd_addr     (rd_addr)
  );

  cpclip_dp #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .rd_addr        (rd_addr),
    .in_vertex_index(in_tdata[3:0]),
    .in_start_x     (in_tdata[19:4]),
    .in_start_y     (in_tdata[35:20]),
    .in_end_x       (in_tdata[51:36]),
    .in_end_y       (in_tdata[67:52]),
    .stat           (stat)
  );

  assign out_tdata = {{(OUT_TDATA_W-1){1'b0}}, out_visible};

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(vertex_count_r) >= MIN_VERTICES) && (int'(vertex_count_r) <= MAX_VERTICES))
    else $error("vertex count outside its clamped range");

  a_segment_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == OPC_SEGMENT)) |=> !in_tready)
    else $error("new item accepted while a segment is in progress");

  a_vertex_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == OPC_VERTEX)) |=> !$rose(out_tvalid))
    else $error("vertex write produced a result");

  a_result_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $rose(in_tready))
    else $error("result appeared without the segment ending");
`endif

endmodule
